@@ rtl/sms_pkg.sv @@
// ----------------------------------------------------------------------------
// sms_pkg: shared types and constants for the sample moment statistics core
// Holds the status codes, field widths, skew bounds and the beat payload types.
// ----------------------------------------------------------------------------
package sms_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SKEW_W   = 24;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FLAT    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

	localparam logic signed [SKEW_W-1:0] SKEW_MAX = 24'sh7FFFFF;
	localparam logic signed [SKEW_W-1:0] SKEW_MIN = -24'sh800000;

	// result beat payload
	typedef struct packed {
		logic [SAMPLE_W-1:0]      sample_mean;
		logic [SAMPLE_W-1:0]      std_deviation;
		logic signed [SKEW_W-1:0] skewness;
		logic [COUNT_W-1:0]       sample_count;
		logic [STATUS_W-1:0]      status;
	} result_t;

	// input beat payload
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} sample_t;

endpackage

@@ rtl/sms_stream_if.sv @@
// ----------------------------------------------------------------------------
// sms_stream_if: valid/ready channel carrying one payload beat
// A beat moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface sms_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/sms_divider.sv @@
// ----------------------------------------------------------------------------
// sms_divider: restoring divider, one quotient bit per cycle
// Computes floor(num / den).
// ----------------------------------------------------------------------------
module sms_divider #(
	parameter int NUM_W = 96,
	parameter int DEN_W = 96
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   shifted;
	logic             take;

	// shift in the next dividend bit and trial-subtract
	always_comb begin
		shifted = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
		take    = shifted >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= busy_q && !start && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], take};
			rem_q <= take ? shifted - {1'b0, den_q} : shifted;
		end
	end

	assign quo = quo_q;
endmodule

@@ rtl/sample_moment_statistics_core.sv @@
// ----------------------------------------------------------------------------
// sample_moment_statistics_core: mean, standard deviation and skewness
// Collects Q0.16 samples into an internal store and reports the moments.
// ----------------------------------------------------------------------------
// Usage:
//   in  : sample beats (sample, last). While collecting, one beat is taken
//         every cycle; each is written to the store and added to the sum.
//   out : one result beat per set, after the beat carrying last.
//   Samples beyond MAX_SAMPLES are dropped and flagged with status 2.
// After the last beat, one shared restoring divider (96 quotient bits) runs
// for the mean, the variance and the skew quotient; one pass over the store
// uses a registered read and a two-stage product; a bit-pair root and the
// product n * s^3 follow. A flat set skips the skew quotient.
// The input is not ready from the last beat until the result is taken and
// is ready again the cycle after; a stalled receiver holds the result and
// the block waits.
// Reset clears the count, overflow flag, sum and sequencer; the store needs
// no clearing since only entries written in the current set are read.
// ----------------------------------------------------------------------------
module sample_moment_statistics_core #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic    clk,
	input  logic    arst_n,
	sms_stream_if.sink   in_s,
	sms_stream_if.source out_s
);
	localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int N_W    = $clog2(MAX_SAMPLES + 1);
	localparam int DIV_W  = 96;

	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_MEAN  = 4'd1;
	localparam logic [3:0] ST_MWAIT = 4'd2;
	localparam logic [3:0] ST_SCAN  = 4'd3;
	localparam logic [3:0] ST_VAR   = 4'd4;
	localparam logic [3:0] ST_VWAIT = 4'd5;
	localparam logic [3:0] ST_ROOT  = 4'd6;
	localparam logic [3:0] ST_CUBE  = 4'd7;
	localparam logic [3:0] ST_SKEW  = 4'd8;
	localparam logic [3:0] ST_SWAIT = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;
	localparam logic [3:0] ST_DEN   = 4'd11;

	logic [3:0]  state_q;
	logic [15:0] store_q [MAX_SAMPLES];
	logic [15:0] rd_s1;
	logic        rd_vld_s1;
	logic signed [16:0] dev_s2;
	logic signed [33:0] dev2_s2;
	logic        vld_s2;
	logic [N_W-1:0]  cnt_q;
	logic [N_W-1:0]  idx_q;
	logic            ovf_q;
	logic [N_W+15:0] sum_q;
	logic [15:0]     mean_q;
	logic [N_W+31:0] s2_q;
	logic signed [N_W+48:0] s3_q;
	logic [15:0]     root_q;
	logic [31:0]     rad_q;
	logic [33:0]     rrem_q;
	logic [4:0]      rcnt_q;
	logic [1:0]      dcnt_q;
	logic [95:0]     den_q;
	logic [95:0]     mag_q;
	logic            neg_q;
	sms_pkg::result_t res_q;
	logic            out_vld_q;

	logic              div_start;
	logic [DIV_W-1:0]  div_num;
	logic [DIV_W-1:0]  div_den;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;

	logic              in_fire;
	logic              full;
	logic signed [16:0] dev;
	logic signed [33:0] dev2;
	logic signed [50:0] dev3;
	logic [33:0]       trial;
	logic [95:0]       mul;

	sms_divider #(.NUM_W(DIV_W), .DEN_W(DIV_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign in_s.ready  = (state_q == ST_LOAD);
	assign in_fire     = in_s.valid && in_s.ready;
	assign full        = (cnt_q == N_W'(MAX_SAMPLES));
	assign out_s.valid = out_vld_q;
	assign out_s.data  = res_q;

	// deviation terms of the current store word
	always_comb begin
		dev  = $signed({1'b0, rd_s1}) - $signed({1'b0, mean_q});
		dev2 = 34'(dev * dev);
		dev3 = 51'(dev2_s2 * dev_s2);
		trial = {rrem_q[31:0], rad_q[31:30]} - {16'd0, root_q, 2'b01};
		mul  = den_q[47:0] * {32'd0, root_q};
	end

	// divider request per stage
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			ST_MEAN: begin
				div_start = 1'b1;
				div_num   = DIV_W'(sum_q);
				div_den   = DIV_W'(cnt_q);
			end
			ST_VAR: begin
				div_start = 1'b1;
				div_num   = DIV_W'(s2_q);
				div_den   = DIV_W'(cnt_q);
			end
			ST_SKEW: begin
				div_start = 1'b1;
				div_num   = mag_q;
				div_den   = den_q;
			end
			default: ;
		endcase
	end

	// store write and registered read
	always_ff @(posedge clk) begin
		if (in_fire && !full) store_q[idx_q[ADDR_W-1:0]] <= in_s.data.sample;
		rd_s1 <= store_q[idx_q[ADDR_W-1:0]];
	end

	// hold the deviation and its square ahead of the cube
	always_ff @(posedge clk) begin
		dev_s2  <= dev;
		dev2_s2 <= dev2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			idx_q     <= '0;
			ovf_q     <= 1'b0;
			sum_q     <= '0;
			out_vld_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			vld_s2    <= 1'b0;
			rcnt_q    <= '0;
			dcnt_q    <= '0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN) && (idx_q < cnt_q);
			vld_s2    <= rd_vld_s1;
			case (state_q)
				// collect beats
				ST_LOAD: begin
					if (in_fire) begin
						if (!full) begin
							cnt_q <= cnt_q + 1'b1;
							idx_q <= idx_q + 1'b1;
							sum_q <= sum_q + (N_W+16)'(in_s.data.sample);
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_s.data.last) state_q <= ST_MEAN;
					end
				end
				ST_MEAN: state_q <= ST_MWAIT;
				ST_MWAIT: begin
					if (div_done) begin
						mean_q  <= div_quo[15:0];
						idx_q   <= '0;
						s2_q    <= '0;
						s3_q    <= '0;
						state_q <= ST_SCAN;
					end
				end
				// one pass over the store: accumulate square and cube
				ST_SCAN: begin
					if (vld_s2) begin
						s2_q <= s2_q + (N_W+32)'($unsigned(dev2_s2));
						s3_q <= s3_q + (N_W+49)'(dev3);
					end
					if (idx_q < cnt_q) begin
						idx_q <= idx_q + 1'b1;
					end else if (!rd_vld_s1 && !vld_s2) begin
						state_q <= ST_VAR;
					end
				end
				ST_VAR: state_q <= ST_VWAIT;
				ST_VWAIT: begin
					if (div_done) begin
						rad_q   <= div_quo[31:0];
						rrem_q  <= '0;
						root_q  <= '0;
						rcnt_q  <= 5'd16;
						state_q <= ST_ROOT;
					end
				end
				// bit-pair square root, one result bit per cycle
				ST_ROOT: begin
					if (!trial[33]) begin
						rrem_q <= trial;
						root_q <= {root_q[14:0], 1'b1};
					end else begin
						rrem_q <= {rrem_q[31:0], rad_q[31:30]};
						root_q <= {root_q[14:0], 1'b0};
					end
					rad_q  <= {rad_q[29:0], 2'b00};
					rcnt_q <= rcnt_q - 1'b1;
					if (rcnt_q == 5'd1) state_q <= ST_CUBE;
				end
				// capture the fixed fields and set up the skew quotient
				ST_CUBE: begin
					res_q.sample_mean   <= mean_q;
					res_q.std_deviation <= root_q;
					res_q.sample_count  <= sms_pkg::COUNT_W'(cnt_q);
					res_q.status        <= ovf_q ? sms_pkg::STATUS_DROPPED :
						(root_q == '0) ? sms_pkg::STATUS_FLAT : sms_pkg::STATUS_OK;
					neg_q  <= s3_q < 0;
					mag_q  <= (s3_q < 0) ? 96'(-s3_q) : 96'(s3_q);
					den_q  <= 96'(cnt_q);
					dcnt_q <= 2'd3;
					if (root_q == '0) begin
						res_q.skewness <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DEN;
					end
				end
				// n * s^3 with three narrow products
				ST_DEN: begin
					den_q  <= mul;
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == 2'd1) begin
						mag_q   <= {mag_q[79:0], 16'd0};
						state_q <= ST_SKEW;
					end
				end
				ST_SKEW: state_q <= ST_SWAIT;
				ST_SWAIT: begin
					if (div_done) begin
						if (neg_q) begin
							res_q.skewness <= (div_quo > 96'd8388608) ?
								sms_pkg::SKEW_MIN : -$signed(div_quo[23:0]);
						end else begin
							res_q.skewness <= (div_quo > 96'd8388607) ?
								sms_pkg::SKEW_MAX : $signed(div_quo[23:0]);
						end
						state_q <= ST_OUT;
					end
				end
				// present result, then reset the set
				ST_OUT: begin
					if (!out_vld_q) begin
						out_vld_q <= 1'b1;
					end else if (out_s.ready) begin
						out_vld_q <= 1'b0;
						cnt_q     <= '0;
						idx_q     <= '0;
						ovf_q     <= 1'b0;
						sum_q     <= '0;
						state_q   <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

@@ dv/tb_sample_moment_statistics_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sample_moment_statistics_core: self-checking bench for the moments core
// Streams sets of Q0.16 samples into the core and predicts the mean, standard
// deviation, skewness, count and status of each set in exact integer
// arithmetic. Each result beat is checked field by field against the oldest
// prediction, while in the later phases both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sample_moment_statistics_core;

	localparam int STORE_DEPTH = 1024;
	localparam int IDLE_LIMIT  = 40000;

	// Predicts the moments of each set and checks the result beats
	class moment_scoreboard;
		logic [sms_pkg::SAMPLE_W-1:0] held_samples[STORE_DEPTH];
		int                           held_count;
		bit                           dropped_seen;
		longint unsigned              sample_sum;
		sms_pkg::result_t             pending_results[$];
		int                           mismatches;

		function void clear_set();
			held_count   = 0;
			dropped_seen = 0;
			sample_sum   = 0;
		endfunction

		function longint unsigned floor_root(longint unsigned v);
			longint unsigned r;
			longint unsigned t;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= v)
					r = t;
			end
			return r;
		endfunction

		function sms_pkg::result_t compute_moments();
			sms_pkg::result_t res;
			longint unsigned  n, mean_q, sq_sum, spread;
			longint           cube_sum, dev;
			longint unsigned  mag;
			logic [127:0]     quot;
			n        = held_count;
			mean_q   = sample_sum / n;
			sq_sum   = 0;
			cube_sum = 0;
			for (int i = 0; i < held_count; i++) begin
				dev      = longint'({48'd0, held_samples[i]}) - longint'(mean_q);
				sq_sum   += longint'(dev * dev);
				cube_sum += dev * dev * dev;
			end
			spread            = floor_root(sq_sum / n);
			res.sample_mean   = mean_q[sms_pkg::SAMPLE_W-1:0];
			res.std_deviation = spread[sms_pkg::SAMPLE_W-1:0];
			res.sample_count  = n[sms_pkg::COUNT_W-1:0];
			if (spread == 0) begin
				res.skewness = '0;
				res.status   = sms_pkg::STATUS_FLAT;
			end else begin
				mag  = (cube_sum < 0) ? longint'(-cube_sum) : longint'(cube_sum);
				quot = ({64'd0, mag} << 16) / {64'd0, n * spread * spread * spread};
				if (cube_sum >= 0)
					res.skewness = (quot > 128'd8388607) ?
						sms_pkg::SKEW_MAX : quot[sms_pkg::SKEW_W-1:0];
				else if (quot >= 128'd8388608)
					res.skewness = sms_pkg::SKEW_MIN;
				else
					res.skewness = -$signed(quot[sms_pkg::SKEW_W-1:0]);
				res.status = sms_pkg::STATUS_OK;
			end
			if (dropped_seen)
				res.status = sms_pkg::STATUS_DROPPED;
			return res;
		endfunction

		function void note_sample(sms_pkg::sample_t beat);
			if (held_count < STORE_DEPTH) begin
				held_samples[held_count] = beat.sample;
				held_count++;
				sample_sum += beat.sample;
			end else begin
				dropped_seen = 1;
			end
			if (beat.last) begin
				pending_results.push_back(compute_moments());
				clear_set();
			end
		endfunction

		function void report(string what, sms_pkg::result_t exp_r,
				sms_pkg::result_t act_r);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected mean %h sd %h skew %h n %0d st %0d,",
					what, exp_r.sample_mean, exp_r.std_deviation, exp_r.skewness,
					exp_r.sample_count, exp_r.status,
					" got mean %h sd %h skew %h n %0d st %0d",
					act_r.sample_mean, act_r.std_deviation, act_r.skewness,
					act_r.sample_count, act_r.status);
		endfunction

		function void check_result(sms_pkg::result_t act_r);
			sms_pkg::result_t exp_r;
			if (pending_results.size() == 0) begin
				report("unexpected beat", '0, act_r);
				return;
			end
			exp_r = pending_results.pop_front();
			if (act_r.sample_mean !== exp_r.sample_mean)
				report("mean", exp_r, act_r);
			if (act_r.std_deviation !== exp_r.std_deviation)
				report("std deviation", exp_r, act_r);
			if (act_r.skewness !== exp_r.skewness)
				report("skewness", exp_r, act_r);
			if (act_r.sample_count !== exp_r.sample_count)
				report("count", exp_r, act_r);
			if (act_r.status !== exp_r.status)
				report("status", exp_r, act_r);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sms_stream_if #(.payload_t(sms_pkg::sample_t)) in_s ();
	sms_stream_if #(.payload_t(sms_pkg::result_t)) out_s ();

	sample_moment_statistics_core #(.MAX_SAMPLES(STORE_DEPTH)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_s   (in_s),
		.out_s  (out_s)
	);

	moment_scoreboard moments = new();
	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int idle_cycles;

	// Free-running clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Receiver: random stalls, with an occasional long hold-off
	initial begin
		int hold_left;
		hold_left   = 0;
		out_s.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_s.ready <= 1'b0;
			end else begin
				out_s.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watch both channels, feed the scoreboard, guard against a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_s.valid && in_s.ready)
				moments.note_sample(in_s.data);
			if (out_s.valid && out_s.ready)
				moments.check_result(out_s.data);
			if ((in_s.valid && in_s.ready) || (out_s.valid && out_s.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Offer one beat and hold it until the core takes it
	task automatic send_sample(logic [sms_pkg::SAMPLE_W-1:0] value, logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_s.valid <= 1'b0;
			@(posedge clk);
		end
		in_s.valid       <= 1'b1;
		in_s.data.sample <= value;
		in_s.data.last   <= is_last;
		do
			@(posedge clk);
		while (!in_s.ready);
	endtask

	// Lower valid and wait for every predicted result to arrive
	task automatic drain_results();
		in_s.valid <= 1'b0;
		@(posedge clk);
		while (moments.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// One set with random content; mode picks the spread of the values
	task automatic send_random_set(int set_len);
		int mode;
		int base;
		logic [sms_pkg::SAMPLE_W-1:0] v;
		mode = $urandom_range(4);
		base = $urandom_range(65535);
		for (int i = 0; i < set_len; i++) begin
			case (mode)
				0: begin
					v = 16'($urandom_range(65535));
				end
				1: begin
					v = 16'((base + $urandom_range(3)) & 16'hFFFF);
				end
				2: begin
					v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				end
				3: begin
					v = ($urandom_range(15) == 0) ? 16'($urandom_range(65535)) : 16'(base);
				end
				default: begin
					v = 16'($urandom_range(255) << $urandom_range(8));
				end
			endcase
			send_sample(v, i == set_len - 1);
		end
	endtask

	initial begin
		int phase;
		arst_n         = 1'b0;
		in_s.valid     = 1'b0;
		in_s.data      = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 0;
		idle_cycles    = 0;
		moments.clear_set();
		moments.mismatches = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single sample, extremes, flat set, strong skew both ways
		send_sample(16'h0000, 1'b1);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		repeat (4) send_sample(16'h1234, 1'b0);
		send_sample(16'h1234, 1'b1);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h8001, 1'b1);
		repeat (5) send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		repeat (5) send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b1);
		send_sample(16'h5555, 1'b0);
		send_sample(16'hAAAA, 1'b1);
		drain_results();

		// Random sets across the idling phases
		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct  = (phase == 1) ? 73 : (phase == 3) ? 30 : 0;
			recv_stall_pct = (phase == 2) ? 73 : (phase == 3) ? 30 : 0;
			for (int k = 0; k < 25; k++)
				send_random_set($urandom_range(1, 12));
			if (phase == 2) begin
				// Hold the receiver off long enough that the input stalls
				hold_request = 3000;
				send_random_set(3);
				send_random_set(4);
				send_random_set(2);
			end
			drain_results();
		end

		// Overfull set: the store fills, later samples drop
		send_idle_pct  = 0;
		recv_stall_pct = 30;
		send_random_set(STORE_DEPTH + 3);
		drain_results();

		// Wait out anything still in flight, then report
		repeat (2000) @(posedge clk);
		if (moments.pending_results.size() != 0)
			moments.mismatches++;
		if (moments.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
